FILE: design/assert_macros.svh
// Assertion macros used by the packer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define PDDP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form: antecedent implies consequent in the same cycle.
`define PDDP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: design/pddp_pkg.sv
// Package: constants, codes and types of the process data datagram packer.
package pddp_pkg;

	localparam int MAX_PAYLOAD = 1486;
	localparam int SEEN_DEPTH  = 64;
	localparam int SEEN_AW     = $clog2(SEEN_DEPTH);
	localparam int SEEN_CW     = $clog2(SEEN_DEPTH + 1);
	localparam int USED_W      = 7;
	localparam int PAIR_W      = 17;

	localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

	// Result kinds
	localparam logic KIND_ENTRY  = 1'b0;
	localparam logic KIND_RECORD = 1'b1;

	// Datagram types
	localparam logic [1:0] DG_READ  = 2'd0;
	localparam logic [1:0] DG_WRITE = 2'd1;
	localparam logic [1:0] DG_RW    = 2'd2;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] rebased_logical;
		logic [31:0] rebased_domain;
		logic [31:0] datagram_address;
		logic [10:0] datagram_bytes;
		logic [1:0]  datagram_type;
		logic [15:0] expected_count;
		logic        oversize;
		logic        last_result;
	} res_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic srch_clr;
		logic srch_step;
		logic rec;
		logic rec_last;
		logic close;
		logic count;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic split;
		logic flush;
		logic last;
		logic srch_done;
	} sts_t;

endpackage

FILE: design/pddp_ifs.sv
// Channel interfaces: mapping entries in, result items out.
interface pddp_entry_if;
	logic        valid;
	logic        ready;
	logic [15:0] slave_config_id;
	logic        direction;
	logic [10:0] transfer_size;
	logic [31:0] log_offset;
	logic [31:0] domain_offset;
	logic        last_entry;

	modport source (output valid, slave_config_id, direction, transfer_size,
		log_offset, domain_offset, last_entry, input ready);
	modport sink (input valid, slave_config_id, direction, transfer_size,
		log_offset, domain_offset, last_entry, output ready);
endinterface

interface pddp_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] rebased_logical;
	logic [31:0] rebased_domain;
	logic [31:0] datagram_address;
	logic [10:0] datagram_bytes;
	logic [1:0]  datagram_type;
	logic [15:0] expected_count;
	logic        oversize;
	logic        last_result;

	modport source (output valid, result_kind, rebased_logical, rebased_domain,
		datagram_address, datagram_bytes, datagram_type, expected_count, oversize,
		last_result, input ready);
	modport sink (input valid, result_kind, rebased_logical, rebased_domain,
		datagram_address, datagram_bytes, datagram_type, expected_count, oversize,
		last_result, output ready);
endinterface

FILE: design/pddp_datapath.sv
// Datapath: open datagram state, pair table search, output register.
module pddp_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [31:0]      cfg_wr_data,
	input  logic [15:0]      slave_config_id,
	input  logic             direction,
	input  logic [10:0]      transfer_size,
	input  logic [31:0]      log_offset,
	input  logic [31:0]      domain_offset,
	input  logic             last_entry,
	input  pddp_pkg::cmd_t   cmd,
	output pddp_pkg::sts_t   sts,
	output pddp_pkg::res_t   res
);
	import pddp_pkg::*;

	logic [31:0]         base_q;
	logic [31:0]         open_off_q;
	logic [10:0]         open_size_q;
	logic [USED_W-1:0]   out_used_q;
	logic [USED_W-1:0]   in_used_q;
	logic [15:0]         exp_q;
	logic [SEEN_CW-1:0]  seen_cnt_q;
	logic [PAIR_W-1:0]   pair_q;
	logic [10:0]         new_size_q;
	logic                split_q;
	logic                flush_q;
	logic                last_q;
	logic [SEEN_CW-1:0]  idx_q;
	logic                pend_s1;
	logic [PAIR_W-1:0]   rd_s1;
	res_t                res_q;

	logic [PAIR_W-1:0]   seen_mem [SEEN_DEPTH];

	logic [11:0]         sum_w;
	logic                split_w;
	logic [10:0]         new_size_w;
	logic                flush_w;
	logic                more_w;
	logic                hit_w;
	logic                store_w;
	logic [8:0]          add_w;
	logic [1:0]          type_w;
	logic [15:0]         exp_new_w;

	// Split decision for the incoming entry
	assign sum_w      = {1'b0, open_size_q} + {1'b0, transfer_size};
	assign split_w    = (open_size_q != 11'd0) && (sum_w > 12'(MAX_PAYLOAD));
	assign new_size_w = split_w ? transfer_size : sum_w[10:0];
	assign flush_w    = last_entry && (new_size_w != 11'd0);

	// Table walk status
	assign more_w  = idx_q < seen_cnt_q;
	assign hit_w   = pend_s1 && (rd_s1 == pair_q);
	assign store_w = cmd.count && !hit_w && (seen_cnt_q < SEEN_CW'(SEEN_DEPTH));

	// Record type and counter increment
	always_comb begin
		if (out_used_q != '0 && in_used_q != '0) begin
			type_w = DG_RW;
			add_w  = {1'b0, out_used_q, 1'b0} + {2'b0, in_used_q};
		end else if (out_used_q != '0) begin
			type_w = DG_WRITE;
			add_w  = {2'b0, out_used_q};
		end else begin
			type_w = DG_READ;
			add_w  = {2'b0, in_used_q};
		end
	end
	assign exp_new_w = exp_q + {7'b0, add_w};

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr_en) begin
			base_q <= cfg_wr_data;
		end
	end

	// Latched entry
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pair_q     <= {slave_config_id, direction};
			new_size_q <= new_size_w;
			split_q    <= split_w;
			flush_q    <= flush_w;
			last_q     <= last_entry;
		end
	end

	// Open datagram state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_off_q  <= '0;
			open_size_q <= '0;
			out_used_q  <= '0;
			in_used_q   <= '0;
			exp_q       <= '0;
			seen_cnt_q  <= '0;
		end else if (cmd.finish) begin
			open_off_q  <= '0;
			open_size_q <= '0;
			out_used_q  <= '0;
			in_used_q   <= '0;
			exp_q       <= '0;
			seen_cnt_q  <= '0;
		end else begin
			if (cmd.rec) begin
				exp_q <= exp_new_w;
			end
			if (cmd.close) begin
				open_off_q  <= open_off_q + {21'b0, open_size_q};
				open_size_q <= '0;
				out_used_q  <= '0;
				in_used_q   <= '0;
				seen_cnt_q  <= '0;
			end else if (cmd.count) begin
				open_size_q <= new_size_q;
				if (store_w) begin
					seen_cnt_q <= seen_cnt_q + SEEN_CW'(1);
				end
				if (!hit_w) begin
					if (pair_q[0]) begin
						if (in_used_q != USED_MAX) in_used_q <= in_used_q + USED_W'(1);
					end else begin
						if (out_used_q != USED_MAX) out_used_q <= out_used_q + USED_W'(1);
					end
				end
			end
		end
	end

	// Table walk: one read issued per step, compared against the pair in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (cmd.srch_clr) begin
			idx_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (cmd.srch_step) begin
			pend_s1 <= more_w;
			idx_q   <= idx_q + SEEN_CW'(more_w);
		end
	end

	// Pair table memory
	always_ff @(posedge clk) begin
		if (store_w) begin
			seen_mem[seen_cnt_q[SEEN_AW-1:0]] <= pair_q;
		end
		if (cmd.srch_step) begin
			rd_s1 <= seen_mem[idx_q[SEEN_AW-1:0]];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			res_q.result_kind      <= KIND_ENTRY;
			res_q.rebased_logical  <= log_offset + base_q;
			res_q.rebased_domain   <= domain_offset + base_q;
			res_q.datagram_address <= '0;
			res_q.datagram_bytes   <= '0;
			res_q.datagram_type    <= DG_READ;
			res_q.expected_count   <= '0;
			res_q.oversize         <= transfer_size > 11'(MAX_PAYLOAD);
			res_q.last_result      <= !split_w && !flush_w;
		end else if (cmd.rec) begin
			res_q.result_kind      <= KIND_RECORD;
			res_q.rebased_logical  <= '0;
			res_q.rebased_domain   <= '0;
			res_q.datagram_address <= base_q + open_off_q;
			res_q.datagram_bytes   <= open_size_q;
			res_q.datagram_type    <= type_w;
			res_q.expected_count   <= exp_new_w;
			res_q.oversize         <= 1'b0;
			res_q.last_result      <= cmd.rec_last;
		end
	end

	assign res = res_q;

	assign sts.split     = split_q;
	assign sts.flush     = flush_q;
	assign sts.last      = last_q;
	assign sts.srch_done = hit_w || (!pend_s1 && !more_w);

endmodule

FILE: design/pddp_ctrl.sv
// Controller: sequences entry result, split record, table walk, count and flush.
`include "assert_macros.svh"

module pddp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  pddp_pkg::sts_t   sts,
	output pddp_pkg::cmd_t   cmd
);
	import pddp_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_WAIT_E = 3'd1;
	localparam logic [2:0] S_SPLIT  = 3'd2;
	localparam logic [2:0] S_WAIT_S = 3'd3;
	localparam logic [2:0] S_SEARCH = 3'd4;
	localparam logic [2:0] S_COUNT  = 3'd5;
	localparam logic [2:0] S_FLUSH  = 3'd6;
	localparam logic [2:0] S_WAIT_F = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_xfer;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_xfer  = out_valid_q && out_ready;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_nx    = S_WAIT_E;
				end
			end
			S_WAIT_E: begin
				if (out_xfer) begin
					cmd.srch_clr = 1'b1;
					state_nx     = sts.split ? S_SPLIT : S_SEARCH;
				end
			end
			S_SPLIT: begin
				cmd.rec      = 1'b1;
				cmd.rec_last = !sts.flush;
				cmd.close    = 1'b1;
				state_nx     = S_WAIT_S;
			end
			S_WAIT_S: begin
				if (out_xfer) begin
					cmd.srch_clr = 1'b1;
					state_nx     = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.srch_done) begin
					state_nx = S_COUNT;
				end else begin
					cmd.srch_step = 1'b1;
				end
			end
			S_COUNT: begin
				cmd.count = 1'b1;
				if (sts.flush) begin
					state_nx = S_FLUSH;
				end else begin
					cmd.finish = sts.last;
					state_nx   = S_IDLE;
				end
			end
			S_FLUSH: begin
				cmd.rec      = 1'b1;
				cmd.rec_last = 1'b1;
				cmd.finish   = 1'b1;
				state_nx     = S_WAIT_F;
			end
			S_WAIT_F: begin
				if (out_xfer) begin
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_in || cmd.rec) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`PDDP_ASSERT_IMP(a_valid_in_wait, out_valid_q, (state_q == S_WAIT_E || state_q == S_WAIT_S || state_q == S_WAIT_F), "result valid outside a wait state")
	`PDDP_ASSERT_IMP(a_split_after_entry, state_q == S_SPLIT, $past(state_q) == S_WAIT_E, "split record not after entry result")
	`PDDP_ASSERT(a_no_overlap, !(in_ready && out_valid_q), "entry taken while a result is pending")

endmodule

FILE: design/process_data_datagram_packer.sv
// Top level of the process data datagram packer.
//
//  channel   | dir | handshake      | payload
//  entry     | in  | valid/ready    | one mapping entry
//  result    | out | valid/ready    | rebased entry or closed datagram record
//  cfg       | in  | cfg_wr_en      | base offset of the domain
//
// One entry at a time: 1 to 3 result transfers plus a walk of the pair table over its
// seen_count stored pairs (seen_count as left after any split).
// The table walk reads one stored pair per cycle from one port.
// Reset clears all control state; the pair table needs no clearing.
// A stalled result holds the block until it is taken.
module process_data_datagram_packer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [31:0]         cfg_wr_data,
	pddp_entry_if.sink          entry,
	pddp_result_if.source       result
);
	import pddp_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res;

	pddp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (entry.valid),
		.in_ready  (entry.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pddp_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.slave_config_id (entry.slave_config_id),
		.direction       (entry.direction),
		.transfer_size   (entry.transfer_size),
		.log_offset      (entry.log_offset),
		.domain_offset   (entry.domain_offset),
		.last_entry      (entry.last_entry),
		.cmd             (cmd),
		.sts             (sts),
		.res             (res)
	);

	assign result.result_kind      = res.result_kind;
	assign result.rebased_logical  = res.rebased_logical;
	assign result.rebased_domain   = res.rebased_domain;
	assign result.datagram_address = res.datagram_address;
	assign result.datagram_bytes   = res.datagram_bytes;
	assign result.datagram_type    = res.datagram_type;
	assign result.expected_count   = res.expected_count;
	assign result.oversize         = res.oversize;
	assign result.last_result      = res.last_result;

endmodule

FILE: verif/pddp_checker.sv
// Result checker: predicts the packer output stream and compares each transfer.
module pddp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	pddp_entry_if       entry,
	pddp_result_if      result,
	output int          fail_count,
	output int          pending
);
	import pddp_pkg::*;

	// Shadow state of the packer
	logic [31:0]       base_q;
	logic [31:0]       dg_offset;
	logic [10:0]       dg_bytes;
	logic [USED_W-1:0] n_out;
	logic [USED_W-1:0] n_in;
	logic [15:0]       wkc_total;
	logic [PAIR_W-1:0] pair_tab [SEEN_DEPTH];
	int                pair_cnt;
	res_t              want_q[$];

	assign pending = want_q.size();

	// Close the open datagram into a record
	function automatic res_t close_datagram();
		res_t r;
		logic [15:0] add;
		r = '0;
		r.result_kind = KIND_RECORD;
		if (n_out != 0 && n_in != 0) begin
			r.datagram_type = DG_RW;
			add = 16'(n_out) * 16'd2 + 16'(n_in);
		end else if (n_out != 0) begin
			r.datagram_type = DG_WRITE;
			add = 16'(n_out);
		end else begin
			r.datagram_type = DG_READ;
			add = 16'(n_in);
		end
		wkc_total = wkc_total + add;
		r.datagram_address = base_q + dg_offset;
		r.datagram_bytes = dg_bytes;
		r.expected_count = wkc_total;
		return r;
	endfunction

	task automatic reopen();
		dg_bytes = '0;
		n_out = '0;
		n_in = '0;
		pair_cnt = 0;
	endtask

	// Predict all results of one accepted entry
	task automatic pack_entry(input logic [15:0] sc, input logic dir, input logic [10:0] tx,
			input logic [31:0] lo, input logic [31:0] dom, input logic last);
		res_t r;
		res_t outs[$];
		logic [PAIR_W-1:0] pair;
		bit found;
		r = '0;
		r.result_kind = KIND_ENTRY;
		r.rebased_logical = lo + base_q;
		r.rebased_domain = dom + base_q;
		r.oversize = (tx > MAX_PAYLOAD);
		outs.push_back(r);
		if (dg_bytes != 0 && 32'(dg_bytes) + 32'(tx) > MAX_PAYLOAD) begin
			outs.push_back(close_datagram());
			dg_offset = dg_offset + 32'(dg_bytes);
			reopen();
		end
		pair = {sc, dir};
		found = 0;
		for (int i = 0; i < pair_cnt; i++)
			if (pair_tab[i] == pair) found = 1;
		if (!found) begin
			if (pair_cnt < SEEN_DEPTH) begin
				pair_tab[pair_cnt] = pair;
				pair_cnt++;
			end
			if (dir) begin
				if (n_in != USED_MAX) n_in++;
			end else if (n_out != USED_MAX) n_out++;
		end
		dg_bytes = dg_bytes + tx;
		if (last) begin
			if (dg_bytes != 0) outs.push_back(close_datagram());
			dg_offset = '0;
			wkc_total = '0;
			reopen();
		end
		outs[outs.size()-1].last_result = 1'b1;
		foreach (outs[i]) want_q.push_back(outs[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t exp_r;
		if (!arst_n) begin
			base_q = '0;
			dg_offset = '0;
			wkc_total = '0;
			reopen();
			want_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_wr_en) base_q = cfg_wr_data;
			if (entry.valid && entry.ready)
				pack_entry(entry.slave_config_id, entry.direction, entry.transfer_size,
					entry.log_offset, entry.domain_offset, entry.last_entry);
			// Compare each result transfer with the oldest prediction
			if (result.valid && result.ready) begin
				got = '{result.result_kind, result.rebased_logical, result.rebased_domain,
					result.datagram_address, result.datagram_bytes, result.datagram_type,
					result.expected_count, result.oversize, result.last_result};
				if (want_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					fail_count++;
				end else begin
					exp_r = want_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

FILE: verif/process_data_datagram_packer_tb.sv
// Testbench top: clock, reset, entry stimulus, receiver stalls and verdict.
module process_data_datagram_packer_tb;
	import pddp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	int          fail_count;
	int          pending;
	bit          long_stall;
	bit          stim_done;

	pddp_entry_if  entry ();
	pddp_result_if result ();

	process_data_datagram_packer dut (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.entry(entry), .result(result)
	);

	pddp_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.entry(entry), .result(result), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Time limit
	initial begin
		#8000000;
		$display("FAIL");
		$finish;
	end

	// Receiver: random stall pattern, one long hold-off requested by stimulus
	initial begin
		int mode;
		result.ready = 0;
		forever begin
			@(negedge clk);
			if (long_stall) begin
				result.ready <= 0;
				for (int i = 0; i < 600; i++) @(negedge clk);
				long_stall = 0;
			end
			mode = ($time / 4000) % 3;
			if (mode == 0) result.ready <= 1;
			else if (mode == 1) result.ready <= ($urandom_range(0, 3) != 0);
			else result.ready <= ($urandom_range(0, 2) == 0);
		end
	end

	// Offer one entry and hold it until taken; valid then drops before the task returns
	task automatic send_entry(input logic [15:0] sc, input logic dir, input logic [10:0] tx,
			input logic [31:0] lo, input logic [31:0] dom, input logic last);
		entry.valid <= 1;
		entry.slave_config_id <= sc;
		entry.direction <= dir;
		entry.transfer_size <= tx;
		entry.log_offset <= lo;
		entry.domain_offset <= dom;
		entry.last_entry <= last;
		do @(posedge clk); while (!entry.ready);
		@(negedge clk);
		entry.valid <= 0;
		@(negedge clk);
	endtask

	task automatic send_rand(input int last_pct, input int big_pct);
		logic [10:0] tx;
		logic [15:0] sc;
		sc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
		if ($urandom_range(0, 99) < big_pct) tx = 11'($urandom);
		else tx = 11'($urandom_range(0, 400));
		send_entry(sc, 1'($urandom), tx, $urandom, $urandom, $urandom_range(0, 99) < last_pct);
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_base(input logic [31:0] v);
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 0;
	endtask

	initial begin
		logic [31:0] bases [4];
		bases = '{32'hFFFF_FFFF, 32'h0, 32'h8000_1234, 32'hFFFF_F000};
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = '0;
		long_stall = 0;
		stim_done = 0;
		entry.valid = 0;
		entry.slave_config_id = '0;
		entry.direction = 0;
		entry.transfer_size = '0;
		entry.log_offset = '0;
		entry.domain_offset = '0;
		entry.last_entry = 0;
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, empty datagram, oversize, splits, flush
		write_base(32'hFFFF_FFFF);
		send_entry(16'hFFFF, 1, 11'd0, 32'hFFFF_FFFF, 32'h0, 1);
		send_entry(16'h0, 0, 11'd2047, 32'h0, 32'hFFFF_FFFF, 0);
		send_entry(16'h0, 0, 11'd1486, 32'h1, 32'h2, 0);
		send_entry(16'h0, 1, 11'd1487, 32'h3, 32'h4, 0);
		send_entry(16'h1, 0, 11'd1, 32'h5, 32'h6, 0);
		send_entry(16'h1, 0, 11'd1, 32'h7, 32'h8, 0);
		send_entry(16'h1, 1, 11'd100, 32'h9, 32'hA, 0);
		send_entry(16'h2, 1, 11'd1400, 32'hB, 32'hC, 1);
		send_entry(16'h3, 1, 11'd10, 32'hD, 32'hE, 0);
		send_entry(16'h3, 1, 11'd10, 32'hF, 32'h10, 1);
		send_entry(16'h4, 0, 11'd5, 32'h11, 32'h12, 1);
		// Fill the pair table past its depth and saturate the output counter
		for (int i = 0; i < 131; i++)
			send_entry(16'(i), 1'(i == 0), 11'd1, $urandom, $urandom, i == 130);
		drain();

		// Random phases over several base settings
		for (int ph = 0; ph < 4; ph++) begin
			write_base(ph == 3 ? $urandom : bases[ph]);
			for (int n = 0; n < 8; n++) begin
				int burst;
				burst = $urandom_range(1, 6);
				for (int k = 0; k < burst; k++) send_rand(12, 15);
				if (ph == 1 && n == 3) begin
					long_stall = 1;
					for (int k = 0; k < 12; k++) send_rand(0, 10);
				end
				if (n == 4) drain();
				if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge clk);
			end
			send_rand(100, 10);
			drain();
		end
		stim_done = 1;
	end

	// Verdict once stimulus finished and results drained
	initial begin
		wait (stim_done);
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end
endmodule
